// ----- rtl/bspe_pkg.sv -----
// ----------------------------------------------------------------------------
// bspe_pkg
// Shared types and constants for the multiword bit vector engine: command
// codes, sequencer states and the default geometry of the vector store.
// ----------------------------------------------------------------------------
package bspe_pkg;

	localparam int WORDS_DEF     = 16;
	localparam int WORD_BITS_DEF = 64;

	localparam int CMD_W  = 3;
	localparam int POS_W  = 10;
	localparam int WIDX_W = 4;
	localparam int WVAL_W = 64;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR = 3'd0,
		CMD_SHL   = 3'd1,
		CMD_SHR   = 3'd2,
		CMD_SET   = 3'd3,
		CMD_READ  = 3'd4,
		CMD_AND   = 3'd5,
		CMD_OR    = 3'd6,
		CMD_POP   = 3'd7
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SPLIT,
		ST_CLEAR,
		ST_SHIFT,
		ST_RD,
		ST_MODIFY,
		ST_CTZ,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

// ----- rtl/bitset_shift_pop_engine_top.sv -----
// ----------------------------------------------------------------------------
// bitset_shift_pop_engine_top
// Bit vector of WORDS words held in a one-read one-write word store, with a
// small sequencer that walks the store for shifts, clears and bound scans.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy then stays high
// until the single result has been shown on the result ports for one cycle
// with done high, and the receiver has no way to hold it off. Every word goes
// through the store's one read and one write port, so each command walks words:
// read bit reads its one word; clear writes every word; the two shifts read
// and rewrite every word in turn; set bit, AND word and OR word modify one
// word, then scan all words to find the lowest nonzero word; pop lowest adds
// to that a bit search, between modify and scan, that halves the word window
// once per cycle. Commands that find nothing to do (out of range index, pop
// on empty) go from the split step straight to done.
module bitset_shift_pop_engine_top
	import bspe_pkg::*;
#(
	parameter int WORDS     = WORDS_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [CMD_W-1:0]  command,
	input  logic [POS_W-1:0]  bit_position,
	input  logic [WIDX_W-1:0] word_index,
	input  logic [WVAL_W-1:0] word_value,
	output logic              done,
	output logic              bit_value,
	output logic              found,
	output logic [POS_W-1:0]  popped_position,
	output logic              is_empty
);

	localparam int IDX_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int CNT_W    = $clog2(WORDS + 1);
	localparam int TZ_W     = $clog2(WORD_BITS);
	localparam int WB_W     = TZ_W + 1;
	localparam int STEP_W   = (TZ_W > 1) ? $clog2(TZ_W) : 1;
	localparam int RECIP_SH = 16;
	localparam int RECIP    = (1 << RECIP_SH) / WORD_BITS;
	localparam int PROD_W   = POS_W + RECIP_SH;
	localparam int MUL_W    = 16;
	localparam int CMP_W    = 8;
	localparam int PF_RAW   = IDX_W + TZ_W + 1;
	localparam int PF_W     = (PF_RAW > POS_W) ? PF_RAW : POS_W;

	state_t state_q, state_d;

	// latched command
	cmd_t                 cmd_q;
	logic [POS_W-1:0]     pos_q;
	logic [WIDX_W-1:0]    widx_q;
	logic [WORD_BITS-1:0] wval_q;
	logic [POS_W-1:0]     qest_q;
	logic [TZ_W-1:0]      b_q;
	logic [IDX_W-1:0]     tgt_q;

	// word store
	logic [WORD_BITS-1:0] mem [WORDS];
	logic [WORDS-1:0]     valid_q;
	logic [WORD_BITS-1:0] rd_raw_s1;
	logic                 rd_vbit_s1;
	logic [WORD_BITS-1:0] rd_data;
	logic                 mem_we;
	logic [IDX_W-1:0]     mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic                 mem_re;
	logic [IDX_W-1:0]     mem_raddr;

	// word walk
	logic [CNT_W-1:0]     cnt_q;
	logic                 pend_s1;
	logic [IDX_W-1:0]     addr_s1;
	logic                 carry_q;
	logic                 walk_rd;
	logic                 walk_end;
	logic                 walk_down;
	logic [IDX_W-1:0]     walk_addr;
	logic [WORD_BITS-1:0] shift_val;
	logic                 carry_d;

	// lowest nonzero word tracking
	logic                 seen_q;
	logic [IDX_W-1:0]     trk_lo_q;
	logic                 trk_en;
	logic                 trk_nz;
	logic                 in_walk;

	// bounds
	logic [IDX_W-1:0]     lowest_q;
	logic                 empty_q;

	// bit search for pop
	logic [WORD_BITS-1:0] y_q;
	logic [TZ_W-1:0]      tz_q;
	logic [STEP_W-1:0]    step_q;
	logic [IDX_W-1:0]     pop_word_q;
	logic [TZ_W-1:0]      half;
	logic [WORD_BITS-1:0] ones;
	logic [WORD_BITS-1:0] low_mask;
	logic                 low_zero;
	logic [TZ_W-1:0]      tz_d;
	logic [PF_W-1:0]      pf;

	// results
	logic                 bit_q;
	logic                 found_q;
	logic [POS_W-1:0]     popped_q;

	// position split
	logic [PROD_W-1:0]    qprod;
	logic [MUL_W-1:0]     qwb;
	logic [MUL_W-1:0]     rem;
	logic [POS_W-1:0]     w_d;
	logic [TZ_W-1:0]      b_d;
	logic                 w_in;
	logic                 widx_in;
	logic [IDX_W-1:0]     tgt_d;

	assign rd_data = rd_vbit_s1 ? rd_raw_s1 : '0;

	assign qprod = PROD_W'(bit_position) * PROD_W'(RECIP);

	always_comb begin
		qwb = MUL_W'(qest_q) * MUL_W'(WORD_BITS);
		rem = MUL_W'(pos_q) - qwb;
		if (rem >= MUL_W'(WORD_BITS)) begin
			w_d = qest_q + POS_W'(1);
			b_d = TZ_W'(rem - MUL_W'(WORD_BITS));
		end else begin
			w_d = qest_q;
			b_d = TZ_W'(rem);
		end
		w_in    = (w_d < POS_W'(WORDS));
		widx_in = (CMP_W'(widx_q) < CMP_W'(WORDS));
		unique case (cmd_q)
			CMD_SET, CMD_READ: tgt_d = IDX_W'(w_d);
			CMD_AND, CMD_OR:   tgt_d = IDX_W'(widx_q);
			default:           tgt_d = lowest_q;
		endcase
	end

	// walk control
	always_comb begin
		walk_rd   = (cnt_q < CNT_W'(WORDS));
		walk_end  = !walk_rd && !pend_s1;
		walk_down = (state_q == ST_SHIFT) && (cmd_q == CMD_SHR);
		walk_addr = walk_down ? (IDX_W'(WORDS - 1) - cnt_q[IDX_W-1:0]) : cnt_q[IDX_W-1:0];
		if (cmd_q == CMD_SHR) begin
			shift_val = (rd_data >> 1) | {carry_q, {(WORD_BITS - 1){1'b0}}};
			carry_d   = rd_data[0];
		end else begin
			shift_val = (rd_data << 1) | {{(WORD_BITS - 1){1'b0}}, carry_q};
			carry_d   = rd_data[WORD_BITS-1];
		end
		in_walk = (state_q == ST_SHIFT) || (state_q == ST_SCAN) || (state_q == ST_CLEAR);
		trk_en  = pend_s1 && ((state_q == ST_SHIFT) || (state_q == ST_SCAN));
		trk_nz  = (state_q == ST_SHIFT) ? (|shift_val) : (|rd_data);
	end

	// bit search step
	always_comb begin
		ones     = '1;
		half     = TZ_W'(1) << step_q;
		low_mask = ones >> (WB_W'(WORD_BITS) - WB_W'(half));
		low_zero = ((y_q & low_mask) == '0);
		tz_d     = low_zero ? (tz_q + half) : tz_q;
		pf       = PF_W'(pop_word_q) * PF_W'(WORD_BITS) + PF_W'(tz_d);
	end

	// sequencer
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = tgt_q;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = tgt_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_SPLIT;
				end
			end
			ST_SPLIT: begin
				unique case (cmd_q)
					CMD_CLEAR:         state_d = ST_CLEAR;
					CMD_SHL, CMD_SHR:  state_d = ST_SHIFT;
					CMD_SET, CMD_READ: state_d = w_in ? ST_RD : ST_DONE;
					CMD_AND, CMD_OR:   state_d = widx_in ? ST_RD : ST_DONE;
					default:           state_d = empty_q ? ST_DONE : ST_RD;
				endcase
			end
			ST_CLEAR: begin
				mem_we    = walk_rd;
				mem_waddr = cnt_q[IDX_W-1:0];
				if (!walk_rd) begin
					state_d = ST_DONE;
				end
			end
			ST_SHIFT: begin
				mem_re    = walk_rd;
				mem_raddr = walk_addr;
				mem_we    = pend_s1;
				mem_waddr = addr_s1;
				mem_wdata = shift_val;
				if (walk_end) begin
					state_d = ST_DONE;
				end
			end
			ST_SCAN: begin
				mem_re    = walk_rd;
				mem_raddr = walk_addr;
				if (walk_end) begin
					state_d = ST_DONE;
				end
			end
			ST_RD: begin
				mem_re  = 1'b1;
				state_d = ST_MODIFY;
			end
			ST_MODIFY: begin
				unique case (cmd_q)
					CMD_READ: begin
						state_d = ST_DONE;
					end
					CMD_SET: begin
						mem_we    = 1'b1;
						mem_wdata = rd_data | (WORD_BITS'(1) << b_q);
						state_d   = ST_SCAN;
					end
					CMD_AND: begin
						mem_we    = 1'b1;
						mem_wdata = rd_data & wval_q;
						state_d   = ST_SCAN;
					end
					CMD_OR: begin
						mem_we    = 1'b1;
						mem_wdata = rd_data | wval_q;
						state_d   = ST_SCAN;
					end
					default: begin
						mem_we    = 1'b1;
						mem_wdata = rd_data & (rd_data - WORD_BITS'(1));
						state_d   = ST_CTZ;
					end
				endcase
			end
			ST_CTZ: begin
				if (step_q == '0) begin
					state_d = ST_SCAN;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// word store, entries read as zero until first written after reset
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_raw_s1 <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_vbit_s1 <= 1'b0;
		end else begin
			if (mem_we) begin
				valid_q[mem_waddr] <= 1'b1;
			end
			if (mem_re) begin
				rd_vbit_s1 <= valid_q[mem_raddr];
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			pend_s1  <= 1'b0;
			carry_q  <= 1'b0;
			seen_q   <= 1'b0;
			trk_lo_q <= '0;
			lowest_q <= '0;
			empty_q  <= 1'b1;
			step_q   <= '0;
			bit_q    <= 1'b0;
			found_q  <= 1'b0;
			popped_q <= '0;
		end else begin
			if (!in_walk) begin
				cnt_q    <= '0;
				pend_s1  <= 1'b0;
				carry_q  <= 1'b0;
				seen_q   <= 1'b0;
				trk_lo_q <= '0;
			end else begin
				if (walk_rd) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
				pend_s1 <= walk_rd && (state_q != ST_CLEAR);
				if (pend_s1 && (state_q == ST_SHIFT)) begin
					carry_q <= carry_d;
				end
				if (trk_en && trk_nz) begin
					seen_q <= 1'b1;
					if (walk_down || !seen_q) begin
						trk_lo_q <= addr_s1;
					end
				end
			end
			if (state_q == ST_CLEAR && !walk_rd) begin
				lowest_q <= '0;
				empty_q  <= 1'b1;
			end
			if ((state_q == ST_SHIFT || state_q == ST_SCAN) && walk_end) begin
				lowest_q <= trk_lo_q;
				empty_q  <= !seen_q;
			end
			if (state_q == ST_IDLE && start) begin
				bit_q    <= 1'b0;
				found_q  <= 1'b0;
				popped_q <= '0;
			end
			if (state_q == ST_MODIFY) begin
				if (cmd_q == CMD_READ) begin
					bit_q <= rd_data[b_q];
				end
				if (cmd_q == CMD_POP) begin
					found_q <= 1'b1;
					step_q  <= STEP_W'(TZ_W - 1);
				end
			end
			if (state_q == ST_CTZ) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == '0) begin
					popped_q <= pf[POS_W-1:0];
				end
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			cmd_q  <= cmd_t'(command);
			pos_q  <= bit_position;
			widx_q <= word_index;
			wval_q <= word_value[WORD_BITS-1:0];
			qest_q <= qprod[RECIP_SH +: POS_W];
		end
		if (state_q == ST_SPLIT) begin
			b_q   <= b_d;
			tgt_q <= tgt_d;
		end
		if (in_walk) begin
			addr_s1 <= walk_addr;
		end
		if (state_q == ST_MODIFY) begin
			y_q        <= rd_data & (~rd_data + WORD_BITS'(1));
			tz_q       <= '0;
			pop_word_q <= tgt_q;
		end
		if (state_q == ST_CTZ) begin
			tz_q <= tz_d;
			if (low_zero) begin
				y_q <= y_q >> half;
			end
		end
	end

	assign busy            = (state_q != ST_IDLE);
	assign done            = (state_q == ST_DONE);
	assign bit_value       = bit_q;
	assign found           = found_q;
	assign popped_position = popped_q;
	assign is_empty        = empty_q;

endmodule

// ----- test/tb_bitset_shift_pop_engine_top.sv -----
// ----------------------------------------------------------------------------
// tb_bitset_shift_pop_engine_top
// Self-checking bench for the multiword bit vector engine. A directed run
// covers the vector ends, word boundaries, every command and pop on an empty
// vector; random command streams with biased positions and word operands
// follow. A flat shadow vector predicts each result, checked field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_bitset_shift_pop_engine_top
	import bspe_pkg::*;
();

	localparam int VEC_BITS = WORDS_DEF * WORD_BITS_DEF;

	typedef struct {
		cmd_t              op;
		logic [POS_W-1:0]  pos;
		logic [WIDX_W-1:0] widx;
		logic [WVAL_W-1:0] wval;
		int unsigned       gap;
	} bit_cmd_t;

	typedef struct {
		logic             bit_value;
		logic             found;
		logic [POS_W-1:0] popped_position;
		logic             is_empty;
	} engine_result_t;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [CMD_W-1:0]  command = '0;
	logic [POS_W-1:0]  bit_position = '0;
	logic [WIDX_W-1:0] word_index = '0;
	logic [WVAL_W-1:0] word_value = '0;
	logic              done;
	logic              bit_value;
	logic              found;
	logic [POS_W-1:0]  popped_position;
	logic              is_empty;

	bit_cmd_t       pending_cmds[$];
	engine_result_t expected_results[$];
	logic [VEC_BITS-1:0] shadow_bits = '0;
	bit_cmd_t       next_cmd;
	engine_result_t want;
	bit             start_hold = 1'b0;
	bit             cmd_taken = 1'b0;
	bit             calm_stretch = 1'b0;
	int unsigned    wait_cnt = 0;
	int unsigned    failures = 0;

	bitset_shift_pop_engine_top i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.command         (command),
		.bit_position    (bit_position),
		.word_index      (word_index),
		.word_value      (word_value),
		.done            (done),
		.bit_value       (bit_value),
		.found           (found),
		.popped_position (popped_position),
		.is_empty        (is_empty)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	task automatic add_cmd(input cmd_t op, input logic [POS_W-1:0] pos,
		input logic [WIDX_W-1:0] widx, input logic [WVAL_W-1:0] wval);
		bit_cmd_t c;
		c.op   = op;
		c.pos  = pos;
		c.widx = widx;
		c.wval = wval;
		c.gap  = calm_stretch ? 0 : $urandom_range(0, 4);
		pending_cmds.push_back(c);
	endtask

	function automatic logic [WVAL_W-1:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return 64'h5555555555555555;
			3: return 64'h3333333333333333;
			4: return 64'h0f0f0f0f0f0f0f0f;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [POS_W-1:0] pick_position();
		case ($urandom_range(0, 5))
			0: return {4'($urandom_range(0, 15)), 6'd0};
			1: return {4'($urandom_range(0, 15)), 6'd63};
			2, 3: return POS_W'($urandom_range(0, 127));
			default: return POS_W'($urandom);
		endcase
	endfunction

	task automatic predict_command(input cmd_t op, input logic [POS_W-1:0] pos,
		input logic [WIDX_W-1:0] widx, input logic [WVAL_W-1:0] wval);
		engine_result_t res;
		int unsigned k;
		res = '{default: '0};
		case (op)
			CMD_CLEAR: shadow_bits = '0;
			CMD_SHL:   shadow_bits = shadow_bits << 1;
			CMD_SHR:   shadow_bits = shadow_bits >> 1;
			CMD_SET:   shadow_bits[pos] = 1'b1;
			CMD_READ:  res.bit_value = shadow_bits[pos];
			CMD_AND:   shadow_bits[widx*WORD_BITS_DEF +: WORD_BITS_DEF] &= wval;
			CMD_OR:    shadow_bits[widx*WORD_BITS_DEF +: WORD_BITS_DEF] |= wval;
			CMD_POP: begin
				if (shadow_bits != '0) begin
					k = 0;
					while (!shadow_bits[k])
						k++;
					shadow_bits[k] = 1'b0;
					res.found = 1'b1;
					res.popped_position = k[POS_W-1:0];
				end
			end
			default: ;
		endcase
		res.is_empty = (shadow_bits == '0);
		expected_results.push_back(res);
	endtask

	function automatic void check_field(string name, logic [63:0] exp_val,
		logic [63:0] got_val);
		if (exp_val !== got_val) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name,
				exp_val, got_val);
			failures++;
		end
	endfunction

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (start_hold && cmd_taken) begin
				start_hold = 1'b0;
				wait_cnt = (pending_cmds.size() != 0) ? pending_cmds[0].gap : 0;
			end
			cmd_taken = 1'b0;
			if (!start_hold && wait_cnt == 0 && pending_cmds.size() != 0) begin
				next_cmd = pending_cmds.pop_front();
				start_hold = 1'b1;
				command <= next_cmd.op;
				bit_position <= next_cmd.pos;
				word_index <= next_cmd.widx;
				word_value <= next_cmd.wval;
			end else if (!start_hold) begin
				if (wait_cnt != 0 && !busy)
					wait_cnt--;
				command <= CMD_W'($urandom);
				bit_position <= POS_W'($urandom);
				word_index <= WIDX_W'($urandom);
				word_value <= {$urandom, $urandom};
			end
			start <= start_hold;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				predict_command(cmd_t'(command), bit_position, word_index, word_value);
				cmd_taken = 1'b1;
			end
			if (done) begin
				if (expected_results.size() == 0) begin
					$display("%0t: expected no result, got %0b %0b %0d %0b",
						$time, bit_value, found, popped_position, is_empty);
					failures++;
				end else begin
					want = expected_results.pop_front();
					check_field("bit_value", want.bit_value, bit_value);
					check_field("found", want.found, found);
					check_field("popped_position", want.popped_position, popped_position);
					check_field("is_empty", want.is_empty, is_empty);
				end
			end
		end
	end

	initial begin
		int unsigned sel;
		int unsigned burst;

		// directed: ends of the vector, word carries, empty cases
		calm_stretch = 1'b1;
		add_cmd(CMD_CLEAR, '0, '0, '0);
		add_cmd(CMD_READ, 10'd1023, '0, '0);
		add_cmd(CMD_POP, '0, '0, '0);
		add_cmd(CMD_SET, 10'd0, '0, '0);
		add_cmd(CMD_SET, 10'd1023, '0, '0);
		add_cmd(CMD_READ, 10'd1023, '0, '0);
		add_cmd(CMD_READ, 10'd1022, '0, '0);
		add_cmd(CMD_SHL, '0, '0, '0);
		add_cmd(CMD_READ, 10'd1, '0, '0);
		add_cmd(CMD_SHR, '0, '0, '0);
		add_cmd(CMD_POP, '0, '0, '0);
		add_cmd(CMD_OR, '0, 4'd15, '1);
		add_cmd(CMD_AND, '0, 4'd15, 64'h5555555555555555);
		add_cmd(CMD_SHR, '0, '0, '0);
		add_cmd(CMD_POP, '0, '0, '0);
		add_cmd(CMD_OR, '0, 4'd0, 64'h8000000000000000);
		add_cmd(CMD_SHL, '0, '0, '0);
		add_cmd(CMD_READ, 10'd64, '0, '0);
		add_cmd(CMD_AND, '0, 4'd1, '0);
		add_cmd(CMD_AND, '0, 4'd15, '0);
		add_cmd(CMD_POP, '0, '0, '0);
		add_cmd(CMD_OR, '0, 4'd7, 64'h0f0f0f0f0f0f0f0f);
		add_cmd(CMD_SHR, '0, '0, '0);
		add_cmd(CMD_CLEAR, '0, '0, '0);
		add_cmd(CMD_POP, '0, '0, '0);

		for (int i = 0; i < 1000; i++) begin
			if (i % 60 == 0)
				calm_stretch = ($urandom_range(0, 2) == 0);
			sel = $urandom_range(0, 99);
			if (sel < 3)
				add_cmd(CMD_CLEAR, POS_W'($urandom), WIDX_W'($urandom),
					{$urandom, $urandom});
			else if (sel < 11)
				add_cmd(CMD_SHL, POS_W'($urandom), WIDX_W'($urandom),
					{$urandom, $urandom});
			else if (sel < 19)
				add_cmd(CMD_SHR, POS_W'($urandom), WIDX_W'($urandom),
					{$urandom, $urandom});
			else if (sel < 39)
				add_cmd(CMD_SET, pick_position(), WIDX_W'($urandom), {$urandom, $urandom});
			else if (sel < 54)
				add_cmd(CMD_READ, pick_position(), WIDX_W'($urandom), {$urandom, $urandom});
			else if (sel < 64)
				add_cmd(CMD_AND, POS_W'($urandom), WIDX_W'($urandom), pick_operand());
			else if (sel < 76)
				add_cmd(CMD_OR, POS_W'($urandom), WIDX_W'($urandom), pick_operand());
			else begin
				burst = $urandom_range(1, 3);
				repeat (burst)
					add_cmd(CMD_POP, POS_W'($urandom), WIDX_W'($urandom),
						{$urandom, $urandom});
			end
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_cmds.size() != 0 || start)
			@(posedge clk);
		@(negedge clk);
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (40) @(posedge clk);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#5000000;
		$display("%0t: timeout", $time);
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- bitset_shift_pop_engine_top.f -----
rtl/bspe_pkg.sv
rtl/bitset_shift_pop_engine_top.sv
test/tb_bitset_shift_pop_engine_top.sv
